[rtl/lps_pkg.sv]
// ----------------------------------------------------------------------------
// lps_pkg
// Shared codes and types for the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ADD       = 3'd1,
        OP_PLAY      = 3'd2,
        OP_STOP      = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_REC_START = 3'd5,
        OP_SWITCH    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_DONE  = 3'd3,
        ST_BUSY  = 3'd4
    } status_t;

    typedef enum logic {
        CFG_SPEED_TICKS = 1'b0,
        CFG_LOOP_ENABLE = 1'b1
    } cfg_index_t;

    localparam logic [7:0] SPEED_RESET   = 8'd20;
    localparam logic       LOOP_RESET    = 1'b1;
    localparam logic [7:0] CAPTURE_MASK  = 8'hFE;
    localparam int         SW_CAPTURE    = 0;
    localparam int         SW_FINISH     = 7;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        logic [7:0] led_value;
        logic       led_update;
        status_t    status;
    } result_t;

endpackage

[rtl/lps_store.sv]
// ----------------------------------------------------------------------------
// lps_store
// Pattern memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lps_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a write to the address being read shows at once
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lps_ctrl.sv]
// ----------------------------------------------------------------------------
// lps_ctrl
// Sequencer state, per-request update logic and result register.
// ----------------------------------------------------------------------------
module lps_ctrl #(
    parameter int MAX_PATTERNS = 16,
    parameter int IDXW         = $clog2(MAX_PATTERNS),
    parameter int CNTW         = $clog2(MAX_PATTERNS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lps_pkg::item_t    item,
    input  logic [7:0]        speed_ticks,
    input  logic              loop_enable,
    input  logic [7:0]        rd_data,
    output logic              mem_we,
    output logic [IDXW-1:0]   mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic [IDXW-1:0]   mem_raddr,
    output logic              done,
    output lps_pkg::result_t  res,
    output logic [CNTW-1:0]   count,
    output logic              playing,
    output logic              recording
);

    localparam logic [CNTW-1:0] MAX_COUNT = CNTW'(MAX_PATTERNS);

    logic [CNTW-1:0]  count_reg, count_next;
    logic [IDXW-1:0]  idx_reg, idx_next;
    logic             play_reg, play_next;
    logic             rec_reg, rec_next;
    logic [7:0]       div_reg, div_next;
    logic [7:0]       last_sw_reg, last_sw_next;
    logic             done_reg;
    lps_pkg::result_t res_reg, res_next;

    logic [7:0]       period;
    logic [8:0]       div_inc;
    logic [CNTW-1:0]  idx_inc;
    logic             full;

    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        play_next    = play_reg;
        rec_next     = rec_reg;
        div_next     = div_reg;
        last_sw_next = last_sw_reg;
        res_next.led_value  = 8'd0;
        res_next.led_update = 1'b0;
        res_next.status     = lps_pkg::ST_OK;
        mem_we    = 1'b0;
        mem_wdata = item.value;

        period  = (speed_ticks == 8'd0) ? 8'd1 : speed_ticks;
        div_inc = {1'b0, div_reg} + 9'd1;
        idx_inc = CNTW'(idx_reg) + CNTW'(1);
        full    = (count_reg >= MAX_COUNT);

        if (in_valid)
        begin
            case (item.op)
                lps_pkg::OP_TICK:
                begin
                    div_next = (div_inc >= {1'b0, period}) ? 8'd0 : div_inc[7:0];
                    if ((div_reg == 8'd0) && play_reg)
                    begin
                        res_next.led_value  = rd_data;
                        res_next.led_update = 1'b1;
                        if (idx_inc >= count_reg)
                        begin
                            idx_next = '0;
                            if (!loop_enable)
                            begin
                                play_next          = 1'b0;
                                res_next.led_value = 8'd0;
                                res_next.status    = lps_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            idx_next = idx_inc[IDXW-1:0];
                        end
                    end
                end
                lps_pkg::OP_ADD:
                begin
                    if (rec_reg)
                    begin
                        res_next.status = lps_pkg::ST_BUSY;
                    end
                    else if (full)
                    begin
                        res_next.status = lps_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                end
                lps_pkg::OP_PLAY:
                begin
                    if (rec_reg)
                    begin
                        res_next.status = lps_pkg::ST_BUSY;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = lps_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        play_next = 1'b1;
                        idx_next  = '0;
                    end
                end
                lps_pkg::OP_STOP:
                begin
                    if (rec_reg)
                    begin
                        res_next.status = lps_pkg::ST_BUSY;
                    end
                    else
                    begin
                        play_next           = 1'b0;
                        res_next.led_update = 1'b1;
                    end
                end
                lps_pkg::OP_CLEAR:
                begin
                    if (rec_reg)
                    begin
                        res_next.status = lps_pkg::ST_BUSY;
                    end
                    else
                    begin
                        count_next          = '0;
                        play_next           = 1'b0;
                        idx_next            = '0;
                        res_next.led_update = 1'b1;
                    end
                end
                lps_pkg::OP_REC_START:
                begin
                    if (rec_reg)
                    begin
                        res_next.status = lps_pkg::ST_BUSY;
                    end
                    else
                    begin
                        play_next    = 1'b0;
                        idx_next     = '0;
                        count_next   = '0;
                        rec_next     = 1'b1;
                        last_sw_next = item.value;
                    end
                end
                lps_pkg::OP_SWITCH:
                begin
                    if (rec_reg)
                    begin
                        // capture on SW0 rise, then finish check on SW7 rise
                        if (item.value[lps_pkg::SW_CAPTURE] && !last_sw_reg[lps_pkg::SW_CAPTURE])
                        begin
                            if (full)
                            begin
                                res_next.status = lps_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we              = 1'b1;
                                mem_wdata           = item.value & lps_pkg::CAPTURE_MASK;
                                count_next          = count_reg + CNTW'(1);
                                res_next.led_value  = item.value & lps_pkg::CAPTURE_MASK;
                                res_next.led_update = 1'b1;
                            end
                        end
                        if (item.value[lps_pkg::SW_FINISH] && !last_sw_reg[lps_pkg::SW_FINISH])
                        begin
                            rec_next = 1'b0;
                        end
                        last_sw_next = item.value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mem_waddr = count_reg[IDXW-1:0];
    // keep the read port one step ahead so rd_data is always store[idx_reg]
    assign mem_raddr = idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            play_reg    <= 1'b0;
            rec_reg     <= 1'b0;
            div_reg     <= 8'd0;
            last_sw_reg <= 8'd0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            play_reg    <= play_next;
            rec_reg     <= rec_next;
            div_reg     <= div_next;
            last_sw_reg <= last_sw_next;
            done_reg    <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done      = done_reg;
    assign res       = res_reg;
    assign count     = count_reg;
    assign playing   = play_reg;
    assign recording = rec_reg;

endmodule

[rtl/led_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// Stores byte-wide LED patterns, plays them back paced by a tick divider and
// records them from switch samples.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  request   | start / busy           | op, value
//  result    | done (1-cycle strobe)  | led_value, led_update, status,
//            |                        | stored_count, playing, recording
//  config    | cfg_write              | cfg_index, cfg_data
//
//  One request is taken per clock; busy stays low.
//  A request passes through the request register, then the update logic into
//  the result register; done is registered alongside the result.
//  The per-request state update is computed combinationally from the state registers;
//  the pattern memory read is registered and kept aligned to the play index.
//  rst_n clears all control state and reloads speed_ticks = 20, loop_enable = 1.
//  Pattern memory is not cleared; the receiver cannot stall results.
//
module led_pattern_sequencer #(
    parameter int MAX_PATTERNS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          op,
    input  logic [7:0]                          value,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [7:0]                          cfg_data,
    output logic                                done,
    output logic [7:0]                          led_value,
    output logic                                led_update,
    output logic [2:0]                          status,
    output logic [$clog2(MAX_PATTERNS + 1)-1:0] stored_count,
    output logic                                playing,
    output logic                                recording
);

    localparam int IDXW = $clog2(MAX_PATTERNS);
    localparam int CNTW = $clog2(MAX_PATTERNS + 1);

    // request register
    lps_pkg::item_t   item_reg;
    logic             valid_reg;

    // configuration registers
    logic [7:0]       speed_reg;
    logic             loop_reg;

    // memory port
    logic             mem_we;
    logic [IDXW-1:0]  mem_waddr;
    logic [7:0]       mem_wdata;
    logic [IDXW-1:0]  mem_raddr;
    logic [7:0]       mem_rdata;

    lps_pkg::result_t res;
    logic             accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            speed_reg <= lps_pkg::SPEED_RESET;
            loop_reg  <= lps_pkg::LOOP_RESET;
        end
        else
        begin
            valid_reg <= accept;
            if (cfg_write)
            begin
                case (lps_pkg::cfg_index_t'(cfg_index))
                    lps_pkg::CFG_SPEED_TICKS: speed_reg <= cfg_data;
                    lps_pkg::CFG_LOOP_ENABLE: loop_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op    <= lps_pkg::op_t'(op);
            item_reg.value <= value;
        end
    end

    lps_ctrl #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .IDXW         (IDXW),
        .CNTW         (CNTW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (valid_reg),
        .item         (item_reg),
        .speed_ticks  (speed_reg),
        .loop_enable  (loop_reg),
        .rd_data      (mem_rdata),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .done         (done),
        .res          (res),
        .count        (stored_count),
        .playing      (playing),
        .recording    (recording)
    );

    lps_store #(
        .DEPTH (MAX_PATTERNS),
        .AW    (IDXW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign led_value  = res.led_value;
    assign led_update = res.led_update;
    assign status     = res.status;

endmodule

[rtl/lps_checker.sv]
// ----------------------------------------------------------------------------
// lps_checker
// Port-level assertions for the LED pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker #(
    parameter int MAX_PATTERNS = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [7:0]                          led_value,
    input logic                                led_update,
    input logic [2:0]                          status,
    input logic [$clog2(MAX_PATTERNS + 1)-1:0] stored_count,
    input logic                                playing,
    input logic                                recording
);

    // every accepted request gets its result through the request and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted request produced no result");

    // and no result appears without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##2 !done)
        else $error("result without a request");

    a_led_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !led_update) |-> (led_value == 8'd0))
        else $error("led_value set without led_update");

    a_busy_recording: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == lps_pkg::ST_BUSY)) |-> recording)
        else $error("busy status outside record mode");

    a_play_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && playing) |-> (stored_count != '0))
        else $error("playing with an empty store");

endmodule

bind led_pattern_sequencer lps_checker #(.MAX_PATTERNS(MAX_PATTERNS)) u_lps_checker (.*);
